// ----- rtl/core/multiphase_delta_coder_unit_defines.svh -----
// ----------------------------------------------------------------------------
// multiphase_delta_coder_unit_defines
// assertion macros for the multiphase delta coder, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef MULTIPHASE_DELTA_CODER_UNIT_DEFINES_SVH
`define MULTIPHASE_DELTA_CODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// check under reset gating
`define MDC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("mdc assertion failed");

// check that also holds while reset is asserted
`define MDC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("mdc assertion failed");

`else

`define MDC_ASSERT(label, clk, rst_n, prop)
`define MDC_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ----- rtl/core/mdc_pkg.sv -----
// ----------------------------------------------------------------------------
// mdc_pkg
// shared types and constants of the multiphase delta coder
// ----------------------------------------------------------------------------
`default_nettype none

package mdc_pkg;

    localparam int DEF_MAX_VALUE_BITS = 32;
    localparam int DEF_MAX_PHASES     = 16;

    localparam int SAMPLE_W   = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int VBITS_W    = 6;
    localparam int PCOUNT_W   = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIRECTION   = 8'd0,
        REG_SIGNED_MODE = 8'd1,
        REG_VALUE_BITS  = 8'd2,
        REG_PHASE_COUNT = 8'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_PHASE = 2'd2
    } status_t;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // effective configuration, widths and counts already clamped
    typedef struct packed {
        logic                direction;
        logic                signed_mode;
        logic [VBITS_W-1:0]  width;
        logic [PCOUNT_W-1:0] phases;
    } cfg_t;

    // outcome of one read-modify-write step
    typedef struct packed {
        logic    wr_en;
        logic    advance;
        status_t status;
    } step_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/mdc_ram.sv -----
// ----------------------------------------------------------------------------
// mdc_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module mdc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/core/mdc_cfg.sv -----
// ----------------------------------------------------------------------------
// mdc_cfg
// configuration registers and clamping to effective width and phase count
// ----------------------------------------------------------------------------
`default_nettype none

module mdc_cfg #(
    parameter int MAX_VALUE_BITS = 32,
    parameter int MAX_PHASES     = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [mdc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mdc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output mdc_pkg::cfg_t                         cfg
);
    import mdc_pkg::*;

    localparam int VCAP = (MAX_VALUE_BITS < SAMPLE_W) ? MAX_VALUE_BITS : SAMPLE_W;
    localparam int PMAX = (1 << PCOUNT_W) - 1;
    localparam int PCAP = (MAX_PHASES < PMAX) ? MAX_PHASES : PMAX;

    logic                direction_reg;
    logic                signed_mode_reg;
    logic [VBITS_W-1:0]  value_bits_reg;
    logic [PCOUNT_W-1:0] phase_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg   <= DIR_ENCODE;
            signed_mode_reg <= 1'b0;
            value_bits_reg  <= VBITS_W'(32);
            phase_count_reg <= PCOUNT_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_DIRECTION:   direction_reg   <= cfg_data[0];
                REG_SIGNED_MODE: signed_mode_reg <= cfg_data[0];
                REG_VALUE_BITS:  value_bits_reg  <= cfg_data[VBITS_W-1:0];
                REG_PHASE_COUNT: phase_count_reg <= cfg_data[PCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.direction   = direction_reg;
        cfg.signed_mode = signed_mode_reg;

        if (value_bits_reg == '0) begin
            cfg.width = VBITS_W'(1);
        end else if (value_bits_reg > VBITS_W'(VCAP)) begin
            cfg.width = VBITS_W'(VCAP);
        end else begin
            cfg.width = value_bits_reg;
        end

        if (phase_count_reg == '0) begin
            cfg.phases = PCOUNT_W'(1);
        end else if (phase_count_reg > PCOUNT_W'(PCAP)) begin
            cfg.phases = PCOUNT_W'(PCAP);
        end else begin
            cfg.phases = phase_count_reg;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/mdc_alu.sv -----
// ----------------------------------------------------------------------------
// mdc_alu
// difference or sum against the stored value, range check, next phase
// ----------------------------------------------------------------------------
`default_nettype none

module mdc_alu #(
    parameter int DW = 32,
    parameter int PW = 4
) (
    input  wire mdc_pkg::cfg_t   cfg,
    input  wire logic [DW-1:0]   sample,
    input  wire logic [DW-1:0]   prev,
    input  wire logic [PW-1:0]   phase,
    input  wire logic            last,
    output logic      [DW-1:0]   coded,
    output logic      [DW-1:0]   wr_data,
    output logic      [PW-1:0]   phase_next,
    output mdc_pkg::step_ctl_t   ctl
);
    import mdc_pkg::*;

    localparam int CW = (PW + 1 > PCOUNT_W) ? PW + 1 : PCOUNT_W;

    logic [DW-1:0] mask;
    logic [DW-1:0] s_val;
    logic [DW-1:0] p_val;
    logic [DW:0]   diff;
    logic [DW-1:0] sum;
    logic          ovf;
    logic          range_bad;
    logic [CW-1:0] inc;

    always_comb begin
        for (int i = 0; i < DW; i++) begin
            mask[i] = (7'(i) < {1'b0, cfg.width});
        end
        s_val = sample & mask;
        p_val = prev & mask;
        diff  = {1'b0, s_val} - {1'b0, p_val};
        sum   = (s_val + p_val) & mask;

        // difference must be a sign extension from bit width-1
        ovf = 1'b0;
        for (int j = 0; j < DW; j++) begin
            if ((7'(j) + 7'd1 >= {1'b0, cfg.width}) && (diff[j] != diff[DW])) begin
                ovf = 1'b1;
            end
        end
        range_bad = (cfg.direction == DIR_ENCODE) && !cfg.signed_mode && ovf;

        if (cfg.direction == DIR_ENCODE) begin
            coded   = range_bad ? '0 : (diff[DW-1:0] & mask);
            wr_data = s_val;
        end else begin
            coded   = sum;
            wr_data = sum;
        end

        ctl.advance = !range_bad;
        ctl.wr_en   = !range_bad;

        inc = CW'(phase) + CW'(1);
        if (!ctl.advance) begin
            phase_next = phase;
        end else if (inc < CW'(cfg.phases)) begin
            phase_next = inc[PW-1:0];
        end else begin
            phase_next = '0;
        end

        if (range_bad) begin
            ctl.status = ST_RANGE;
        end else if (last && (phase_next != '0)) begin
            ctl.status = ST_PHASE;
        end else begin
            ctl.status = ST_OK;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/multiphase_delta_coder_unit.sv -----
// ----------------------------------------------------------------------------
// multiphase_delta_coder_unit
// delta coder over interleaved phases, one stored value per phase in ram
//
//   channel   dir  handshake             payload
//   s_        in   s_tvalid / s_tready   s_tdata sample, s_tlast end_of_stream
//   m_        out  m_tvalid / m_tready   m_tdata coded, m_tuser status,
//                                        m_tlast stream_done
//   cfg_      in   cfg_valid / cfg_ready cfg_index register, cfg_data value
//
// one sample per cycle unless a held result stalls; compute and output stages
// are registered; the ram read of the phase entry is registered, then one add
// or subtract writes it back; a write to the entry read next is forwarded
// aresetn clears phase, stored values (per-entry valid bits) and configuration
// a held result stalls the compute stage, which then holds s_tready low
// ----------------------------------------------------------------------------
`default_nettype none
`include "multiphase_delta_coder_unit_defines.svh"

module multiphase_delta_coder_unit #(
    parameter int MAX_VALUE_BITS = mdc_pkg::DEF_MAX_VALUE_BITS,
    parameter int MAX_PHASES     = mdc_pkg::DEF_MAX_PHASES
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [mdc_pkg::SAMPLE_W-1:0]    s_tdata,  // [31:0] sample
    input  wire logic                            s_tlast,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [mdc_pkg::SAMPLE_W-1:0]    m_tdata,  // [31:0] coded
    output logic      [1:0]                      m_tuser,  // [1:0] status
    output logic                                 m_tlast,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [mdc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [mdc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mdc_pkg::*;

    localparam int DW = (MAX_VALUE_BITS < SAMPLE_W) ? MAX_VALUE_BITS : SAMPLE_W;
    localparam int PW = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;
    localparam logic [PW-1:0] LAST_PHASE = PW'(MAX_PHASES - 1);

    cfg_t      cfg;
    step_ctl_t ctl;

    logic                  s1_valid_reg;
    logic [DW-1:0]         s1_sample_reg;
    logic                  s1_last_reg;
    logic [PW-1:0]         s1_phase_reg;
    logic                  fwd_hit_reg;
    logic [DW-1:0]         fwd_data_reg;
    logic [PW-1:0]         phase_reg;
    logic [MAX_PHASES-1:0] vld_reg;
    logic                  m_tvalid_reg;
    logic [DW-1:0]         m_coded_reg;
    status_t               m_status_reg;
    logic                  m_last_reg;

    logic          s_fire;
    logic          s1_adv;
    logic          wr_en;
    logic [PW-1:0] rd_addr;
    logic [DW-1:0] rd_data;
    logic [DW-1:0] prev;
    logic [DW-1:0] alu_coded;
    logic [DW-1:0] alu_wr_data;
    logic [PW-1:0] phase_next;

    mdc_cfg #(
        .MAX_VALUE_BITS (MAX_VALUE_BITS),
        .MAX_PHASES     (MAX_PHASES)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mdc_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_PHASES),
        .AW    (PW)
    ) u_prev_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (s1_phase_reg),
        .wdata (alu_wr_data),
        .re    (s_fire),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    mdc_alu #(
        .DW (DW),
        .PW (PW)
    ) u_alu (
        .cfg        (cfg),
        .sample     (s1_sample_reg),
        .prev       (prev),
        .phase      (s1_phase_reg),
        .last       (s1_last_reg),
        .coded      (alu_coded),
        .wr_data    (alu_wr_data),
        .phase_next (phase_next),
        .ctl        (ctl)
    );

    assign s1_adv   = s1_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_fire   = s_tvalid && s_tready;
    assign rd_addr  = s1_valid_reg ? (s1_last_reg ? '0 : phase_next) : phase_reg;
    assign wr_en    = s1_adv && ctl.wr_en && !s1_last_reg;

    always_comb begin
        if (fwd_hit_reg) begin
            prev = fwd_data_reg;
        end else if (vld_reg[s1_phase_reg]) begin
            prev = rd_data;
        end else begin
            prev = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            phase_reg    <= '0;
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= wr_en && (s1_phase_reg == rd_addr);
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv) begin
                phase_reg    <= s1_last_reg ? '0 : phase_next;
                m_tvalid_reg <= 1'b1;
                if (s1_last_reg) begin
                    vld_reg <= '0;
                end else if (wr_en) begin
                    vld_reg[s1_phase_reg] <= 1'b1;
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_sample_reg <= s_tdata[DW-1:0];
            s1_last_reg   <= s_tlast;
            s1_phase_reg  <= rd_addr;
            fwd_data_reg  <= alu_wr_data;
        end
        if (s1_adv) begin
            m_coded_reg  <= alu_coded;
            m_status_reg <= ctl.status;
            m_last_reg   <= s1_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = SAMPLE_W'(m_coded_reg);
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    `MDC_ASSERT(a_stall_holds, aclk, aresetn,
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_phase_reg)))
    `MDC_ASSERT(a_write_only_on_advance, aclk, aresetn,
        wr_en |-> (s1_adv && !s1_last_reg))
    `MDC_ASSERT(a_stream_end_clears, aclk, aresetn,
        (s1_adv && s1_last_reg) |=> ((vld_reg == '0) && (phase_reg == '0)))
    `MDC_ASSERT(a_phase_in_range, aclk, aresetn,
        phase_reg <= LAST_PHASE)
    `MDC_ASSERT_ALWAYS(a_reset_empties, aclk,
        (!aresetn) |=> (!s1_valid_reg && !m_tvalid_reg))

endmodule

`default_nettype wire

// ----- tb/mdc_delta_check.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mdc_delta_check
// watches the sample, result and register channels of the multiphase delta
// coder, keeps its own per-phase stored values and phase counter, predicts
// each coded result and compares it field by field with the block's output
// ----------------------------------------------------------------------------
module mdc_delta_check
    import mdc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [SAMPLE_W-1:0]   s_tdata,
    input  wire logic                  s_tlast,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [SAMPLE_W-1:0]   m_tdata,
    input  wire logic [1:0]            m_tuser,
    input  wire logic                  m_tlast,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         mismatches,
    output int                         outstanding
);

    localparam int WIDTH_CAP = (DEF_MAX_VALUE_BITS < SAMPLE_W) ? DEF_MAX_VALUE_BITS : SAMPLE_W;

    typedef struct {
        logic [SAMPLE_W-1:0] coded;
        status_t             status;
        logic                done;
    } delta_result_t;

    delta_result_t expected_codes[$];

    logic                cur_dir;
    logic                cur_sgn;
    logic [VBITS_W-1:0]  cur_vbits;
    logic [PCOUNT_W-1:0] cur_pcount;
    logic [31:0]         stored [DEF_MAX_PHASES];
    int unsigned         phase_idx;

    function automatic logic [63:0] widen(input logic [63:0] x, input int unsigned w,
                                          input logic sgn);
        logic [63:0] m;
        m = (64'd1 << w) - 64'd1;
        x = x & m;
        if (sgn && x[w-1]) begin
            x = x | ~m;
        end
        return x;
    endfunction

    function automatic delta_result_t code_sample(input logic [SAMPLE_W-1:0] smp,
                                                  input logic eos);
        int unsigned   w;
        int unsigned   n;
        logic [63:0]   m;
        logic [63:0]   prv;
        logic [63:0]   v;
        logic [63:0]   diff;
        logic [63:0]   half;
        logic          adv;
        delta_result_t r;
        w = (cur_vbits == 0) ? 1 : ((cur_vbits > WIDTH_CAP) ? WIDTH_CAP : cur_vbits);
        n = (cur_pcount == 0) ? 1 :
            ((cur_pcount > DEF_MAX_PHASES) ? DEF_MAX_PHASES : cur_pcount);
        m = (64'd1 << w) - 64'd1;
        prv = widen(stored[phase_idx], w, cur_sgn);
        r.coded = '0;
        r.status = ST_OK;
        r.done = eos;
        adv = 1'b1;
        if (cur_dir == DIR_ENCODE) begin
            v = widen(smp, w, cur_sgn);
            diff = v - prv;
            half = 64'd1 << (w - 1);
            // unsigned samples must give a difference that fits signed width
            if (!cur_sgn && (diff + half) > m) begin
                r.status = ST_RANGE;
                adv = 1'b0;
            end else begin
                r.coded = diff[31:0] & m[31:0];
                stored[phase_idx] = v[31:0] & m[31:0];
            end
        end else begin
            v = (widen(smp, w, 1'b1) + prv) & m;
            r.coded = v[31:0];
            stored[phase_idx] = v[31:0];
        end
        if (adv) begin
            phase_idx = (phase_idx + 1 < n) ? phase_idx + 1 : 0;
        end
        if (eos) begin
            if (r.status == ST_OK && phase_idx != 0) begin
                r.status = ST_PHASE;
            end
            phase_idx = 0;
            foreach (stored[i]) stored[i] = '0;
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        delta_result_t want;
        int            bad;
        bad = 0;
        if (!aresetn) begin
            cur_dir = DIR_ENCODE;
            cur_sgn = 1'b0;
            cur_vbits = VBITS_W'(32);
            cur_pcount = PCOUNT_W'(1);
            phase_idx = 0;
            foreach (stored[i]) stored[i] = '0;
            expected_codes.delete();
            mismatches <= 0;
        end else begin
            if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
                if (expected_codes.size() == 0) begin
                    $display("%0t: unexpected result transfer: coded %h status %0d last %b",
                             $time, m_tdata, m_tuser, m_tlast);
                    bad++;
                end else begin
                    want = expected_codes.pop_front();
                    if (m_tdata !== want.coded || m_tuser !== want.status ||
                        m_tlast !== want.done) begin
                        $display("%0t: expected coded %h status %0d last %b, got coded %h status %0d last %b",
                                 $time, want.coded, want.status, want.done,
                                 m_tdata, m_tuser, m_tlast);
                        bad++;
                    end
                end
            end
            if (s_tvalid === 1'b1 && s_tready === 1'b1) begin
                expected_codes.push_back(code_sample(s_tdata, s_tlast));
            end
            if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
                case (cfg_index)
                    REG_DIRECTION:   cur_dir = cfg_data[0];
                    REG_SIGNED_MODE: cur_sgn = cfg_data[0];
                    REG_VALUE_BITS:  cur_vbits = cfg_data[VBITS_W-1:0];
                    REG_PHASE_COUNT: cur_pcount = cfg_data[PCOUNT_W-1:0];
                    default: ;
                endcase
            end
            mismatches <= mismatches + bad;
        end
        outstanding <= expected_codes.size();
    end

endmodule

// ----- tb/tb_multiphase_delta_coder_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multiphase_delta_coder_unit
// drives the multiphase delta coder with directed corner items and then
// random streams under a range of register settings, with bursty input,
// receiver stalls and a long receiver hold-off; the checker beside the block
// predicts and compares every result, this module gives the verdict
// ----------------------------------------------------------------------------
module tb_multiphase_delta_coder_unit;
    import mdc_pkg::*;

    localparam int LONG_HOLD = 120;
    localparam int SEGMENTS  = 12;
    localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED = 8'hA7;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [SAMPLE_W-1:0]   m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    mismatches;
    int                    outstanding;

    // stimulus shaping state
    logic        gen_dir = DIR_ENCODE;
    int unsigned gen_width = 32;
    int unsigned gen_phases = 1;
    int unsigned gen_phase = 0;
    logic [31:0] gen_last [DEF_MAX_PHASES] = '{default: '0};
    int unsigned burst_left = 0;
    logic        gaps_on = 1'b1;
    int unsigned rx_ready_pct = 100;
    int unsigned hold_reqs = 0;

    always #2 aclk = ~aclk;

    multiphase_delta_coder_unit dut (.*);

    mdc_delta_check delta_chk (.*);

    // receiver: random ready runs, long hold-off on request
    initial begin
        int unsigned hold_taken;
        int unsigned hold_left;
        int unsigned run_left;
        logic        rdy_level;
        hold_taken = 0;
        hold_left = 0;
        run_left = 0;
        rdy_level = 1'b1;
        forever begin
            @(posedge aclk);
            if (hold_reqs != hold_taken) begin
                hold_taken = hold_reqs;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    rdy_level = ($urandom_range(0, 99) < rx_ready_pct);
                    run_left = $urandom_range(1, 6);
                end
                run_left--;
                m_tready <= rdy_level;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
    endtask

    // upper data bits are random, the block keeps only the register's width
    task automatic apply_config(input logic dir, input logic sgn, input logic [5:0] vb,
                                input logic [4:0] pc, input logic poke_unmapped);
        wait_idle();
        reg_write(REG_DIRECTION, ($urandom() & ~32'h1) | 32'(dir));
        reg_write(REG_SIGNED_MODE, ($urandom() & ~32'h1) | 32'(sgn));
        reg_write(REG_VALUE_BITS, ($urandom() & ~32'h3F) | 32'(vb));
        reg_write(REG_PHASE_COUNT, ($urandom() & ~32'h1F) | 32'(pc));
        if (poke_unmapped) begin
            reg_write(IDX_UNMAPPED, $urandom());
        end
        cfg_valid <= 1'b0;
        gen_dir = dir;
        gen_width = (vb == 0) ? 1 : ((vb > 32) ? 32 : vb);
        gen_phases = (pc == 0) ? 1 : ((pc > DEF_MAX_PHASES) ? DEF_MAX_PHASES : pc);
    endtask

    task automatic push_item(input logic [SAMPLE_W-1:0] smp, input logic eos);
        if (gaps_on && burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata <= smp;
        s_tlast <= eos;
        do @(posedge aclk); while (s_tready !== 1'b1);
        if (burst_left > 0) begin
            burst_left--;
        end
        gen_phase = eos ? 0 : ((gen_phase + 1 < gen_phases) ? gen_phase + 1 : 0);
        if (eos) begin
            gen_last = '{default: '0};
        end
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [31:0] m;
        logic [31:0] r;
        int unsigned sel;
        m = (gen_width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << gen_width) - 32'd1);
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
            r = ((gen_dir == DIR_DECODE) ? 32'd0 : gen_last[gen_phase])
                + $urandom_range(0, 8) - 32'd4;
        end else if (sel < 80) begin
            r = $urandom();
        end else begin
            case ($urandom_range(0, 3))
                0: r = '0;
                1: r = m;
                2: r = m >> 1;
                default: r = (m >> 1) + 32'd1;
            endcase
        end
        if ($urandom_range(0, 3) == 0) begin
            r = (r & m) | ($urandom() & ~m);
        end
        gen_last[gen_phase] = r & m;
        return r;
    endfunction

    function automatic logic [5:0] pick_width();
        case ($urandom_range(0, 11))
            0: return 6'd0;
            1: return 6'd1;
            2: return 6'd2;
            3: return 6'd33;
            4: return 6'd63;
            5, 6: return 6'd32;
            default: return 6'($urandom_range(1, 32));
        endcase
    endfunction

    function automatic logic [4:0] pick_phases();
        case ($urandom_range(0, 9))
            0: return 5'd0;
            1: return 5'd16;
            2: return 5'd17;
            3: return 5'd31;
            default: return 5'($urandom_range(1, 16));
        endcase
    endfunction

    initial begin
        int unsigned len;
        int unsigned sent;
        int unsigned target;
        logic        eos;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: encode, unsigned, full width, one phase
        push_item(32'h7FFF_FFFF, 1'b0);
        push_item(32'hFFFF_FFFF, 1'b0);
        push_item(32'h0000_0000, 1'b0);
        push_item(32'h8000_0000, 1'b1);

        // width and phase count of zero, unmapped register index
        apply_config(DIR_ENCODE, 1'b1, 6'd0, 5'd0, 1'b1);
        push_item(32'h0000_0001, 1'b0);
        push_item(32'h0000_0000, 1'b1);

        // oversized width and phase count, stream ends mid-round
        apply_config(DIR_DECODE, 1'b1, 6'd40, 5'd17, 1'b0);
        push_item(32'h8000_0000, 1'b0);
        push_item(32'h7FFF_FFFF, 1'b0);
        push_item(32'hFFFF_FFFF, 1'b1);

        // one-bit unsigned encode, range errors and phase check
        apply_config(DIR_ENCODE, 1'b0, 6'd1, 5'd3, 1'b0);
        push_item(32'h0000_0001, 1'b0);
        push_item(32'h0000_0000, 1'b0);
        push_item(32'h0000_0001, 1'b0);
        push_item(32'h0000_0000, 1'b0);
        push_item(32'h0000_0001, 1'b1);

        // unsigned decode, garbage above the width
        apply_config(DIR_DECODE, 1'b0, 6'd8, 5'd2, 1'b0);
        push_item(32'h0000_0080, 1'b0);
        push_item(32'h0000_007F, 1'b0);
        push_item(32'hFFFF_FF80, 1'b0);
        push_item(32'h0000_0001, 1'b1);

        // signed encode with wrapping difference
        apply_config(DIR_ENCODE, 1'b1, 6'd32, 5'd2, 1'b0);
        push_item(32'h8000_0000, 1'b0);
        push_item(32'h7FFF_FFFF, 1'b0);
        push_item(32'h7FFF_FFFF, 1'b1);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            apply_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         pick_width(), pick_phases(), 1'b0);
            gaps_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 2))
                0: rx_ready_pct = 100;
                1: rx_ready_pct = 75;
                default: rx_ready_pct = 40;
            endcase
            if (seg == 2 || seg == 7) begin
                gaps_on = 1'b0;
                hold_reqs++;
            end
            target = $urandom_range(40, 56);
            sent = 0;
            while (sent < target) begin
                // mostly whole rounds of phases, sometimes a broken stream
                if ($urandom_range(0, 4) != 0) begin
                    len = gen_phases * $urandom_range(1, 3);
                end else begin
                    len = $urandom_range(1, 2 * gen_phases + 1);
                end
                for (int k = 0; k < len; k++) begin
                    eos = (k == len - 1) && ($urandom_range(0, 7) != 0);
                    push_item(pick_sample(), eos);
                end
                sent += len;
            end
        end

        wait_idle();
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
